// ===== hw/rtl/mlkd_pkg.sv =====
// Shared types and constants of the multi-line key debouncer.
`default_nettype none
package mlkd_pkg;

    // Fixed width of the line vectors on the ports.
    localparam int LINES_MAX     = 16;
    localparam int NUM_LINES_DEF = 16;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // Debounce wait after reset.
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;

    // Stable level code of a switch whose level is not yet known.
    localparam logic [1:0] UNKNOWN_LEVEL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd3;

    // Operation codes of an input item.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Settings and item-wide controls shared by every lane.
    typedef struct packed {
        logic             operation;
        logic             armed;
        logic             pressed_level;
        logic [CNT_W-1:0] debounce;
    } t_lane_ctl;

    // What one lane found on the current item.
    typedef struct packed {
        logic pressed;
        logic changed;
        logic level;
    } t_lane_res;

endpackage
`default_nettype wire

// ===== hw/rtl/mlkd_in_if.sv =====
// Input channel of the debouncer: operation and sampled line levels.
`default_nettype none
interface mlkd_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] line_levels;

    modport source (output valid, output operation, output line_levels, input ready);
    modport sink   (input valid, input operation, input line_levels, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlkd_out_if.sv =====
// Output channel of the debouncer: press, change and switch level vectors.
`default_nettype none
interface mlkd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pressed_lines;
    logic [15:0] changed_switches;
    logic [15:0] switch_levels;

    modport source (output valid, output pressed_lines, output changed_switches,
                    output switch_levels, input ready);
    modport sink   (input valid, input pressed_lines, input changed_switches,
                    input switch_levels, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlkd_lane.sv =====
// One debounce lane: pending flag, wait counter and stable level of one line.
`default_nettype none
module mlkd_lane
    import mlkd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_acc,
    input  wire t_lane_ctl i_ctl,
    input  wire logic      i_is_button,
    input  wire logic      i_is_switch,
    input  wire logic      i_sample,
    output t_lane_res      o_res
);

    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [1:0]       r_stab, n_stab;
    logic [CNT_W-1:0] cnt_inc;
    logic             differs;

    assign cnt_inc = r_cnt + CNT_W'(1);
    assign differs = (r_stab != {1'b0, i_sample});

    // Next lane state and this item's findings.
    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_stab = r_stab;
        o_res  = '0;
        if (i_ctl.operation == OP_START) begin
            if (i_is_button) begin
                n_pend = 1'b0;
                n_cnt  = '0;
                n_stab = {1'b0, i_sample};
            end else if (i_is_switch) begin
                n_pend = 1'b1;
                n_cnt  = i_ctl.debounce - CNT_W'(1);
                n_stab = UNKNOWN_LEVEL;
            end else begin
                n_pend = 1'b0;
                n_cnt  = '0;
                n_stab = '0;
            end
        end else if (i_ctl.armed && (i_is_button || i_is_switch)) begin
            if (r_pend) begin
                n_cnt = cnt_inc;
                if (cnt_inc == i_ctl.debounce) begin
                    if (differs) begin
                        if (i_is_button) begin
                            o_res.pressed = (i_sample == i_ctl.pressed_level);
                        end else begin
                            o_res.changed = 1'b1;
                            o_res.level   = i_sample;
                        end
                    end
                    n_pend = 1'b0;
                    n_cnt  = '0;
                    n_stab = {1'b0, i_sample};
                end
            end else if (differs) begin
                n_pend = 1'b1;
            end
        end
    end

    // Lane state advances on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_stab <= '0;
        end else if (i_acc) begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_stab <= n_stab;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mlkd_merge.sv =====
// Merges lane findings into one result, keeps the switch levels, and buffers
// results in an output register with a skid stage.
`default_nettype none
module mlkd_merge
    import mlkd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire logic [LINES_MAX-1:0] i_pressed,
    input  wire logic [LINES_MAX-1:0] i_changed,
    input  wire logic [LINES_MAX-1:0] i_level,
    input  wire logic                 i_out_ready,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output logic [LINES_MAX-1:0]      o_pressed,
    output logic [LINES_MAX-1:0]      o_changed,
    output logic [LINES_MAX-1:0]      o_levels
);

    logic [LINES_MAX-1:0] r_sw, n_sw;
    logic                 r_out_valid, r_skd_valid;
    logic [LINES_MAX-1:0] r_out_pressed, r_out_changed, r_out_levels;
    logic [LINES_MAX-1:0] r_skd_pressed, r_skd_changed, r_skd_levels;
    logic                 take;

    // Changed switches take their new level, all others hold.
    assign n_sw = (r_sw & ~i_changed) | (i_changed & i_level);

    assign take        = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_skd_valid;
    assign o_out_valid = r_out_valid;
    assign o_pressed   = r_out_pressed;
    assign o_changed   = r_out_changed;
    assign o_levels    = r_out_levels;

    // Debounced switch levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0;
        end else if (i_acc) begin
            r_sw <= n_sw;
        end
    end

    // Output register and skid stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (i_acc) begin
            if (r_out_valid && !take) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payloads.
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (take) begin
                r_out_pressed <= r_skd_pressed;
                r_out_changed <= r_skd_changed;
                r_out_levels  <= r_skd_levels;
            end
        end else if (i_acc) begin
            if (r_out_valid && !take) begin
                r_skd_pressed <= i_pressed;
                r_skd_changed <= i_changed;
                r_skd_levels  <= n_sw;
            end else begin
                r_out_pressed <= i_pressed;
                r_out_changed <= i_changed;
                r_out_levels  <= n_sw;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_line_key_debouncer.sv =====
// Top level of the multi-line key debouncer.
// One debounce lane per line checks its button or switch on every item: a
// start item captures the button levels and sends every switch into a
// resample one tick later, and a scan tick starts, counts or ends the
// debounce wait of each line. The lanes work side by side, so one item is
// taken in every clock cycle unless the skid stage is full; results are
// registered, and a skid stage keeps the input open while one result waits.
// Lines at or above NUM_LINES read as zero in every result. Configuration is
// to be written by the user through a plain write port while no item is in
// flight (not enforced); ticks before the first start item report nothing.
`default_nettype none
module multi_line_key_debouncer
    import mlkd_pkg::*;
#(
    parameter int NUM_LINES = NUM_LINES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mlkd_in_if.sink                    i_in,
    mlkd_out_if.source                 o_out
);

    logic [LINES_MAX-1:0] r_button_mask;
    logic [LINES_MAX-1:0] r_switch_mask;
    logic                 r_pressed_level;
    logic [CNT_W-1:0]     r_debounce;
    logic                 r_armed;
    logic                 acc;
    logic                 in_ready;
    t_lane_ctl            lane_ctl;
    logic [LINES_MAX-1:0] lane_pressed, lane_changed, lane_level;

    assign acc        = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_mask   <= '0;
            r_switch_mask   <= '0;
            r_pressed_level <= 1'b0;
            r_debounce      <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUTTON_MASK:    r_button_mask   <= i_cfg_data[LINES_MAX-1:0];
                CFG_SWITCH_MASK:    r_switch_mask   <= i_cfg_data[LINES_MAX-1:0];
                CFG_PRESSED_LEVEL:  r_pressed_level <= i_cfg_data[0];
                CFG_DEBOUNCE_TICKS: r_debounce      <= i_cfg_data[CNT_W-1:0];
                default:            r_debounce      <= r_debounce;
            endcase
        end
    end

    // The block is armed by the first start item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (acc && i_in.operation == OP_START) begin
            r_armed <= 1'b1;
        end
    end

    assign lane_ctl.operation     = i_in.operation;
    assign lane_ctl.armed         = r_armed;
    assign lane_ctl.pressed_level = r_pressed_level;
    assign lane_ctl.debounce      = r_debounce;

    // One lane per line; lines beyond NUM_LINES report nothing.
    for (genvar g = 0; g < LINES_MAX; g++) begin : g_line
        if (g < NUM_LINES) begin : g_lane
            t_lane_res res;

            mlkd_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_acc       (acc),
                .i_ctl       (lane_ctl),
                .i_is_button (r_button_mask[g]),
                .i_is_switch (!r_button_mask[g] && r_switch_mask[g]),
                .i_sample    (i_in.line_levels[g]),
                .o_res       (res)
            );

            assign lane_pressed[g] = res.pressed;
            assign lane_changed[g] = res.changed;
            assign lane_level[g]   = res.level;
        end else begin : g_unused
            assign lane_pressed[g] = 1'b0;
            assign lane_changed[g] = 1'b0;
            assign lane_level[g]   = 1'b0;
        end
    end

    // Merge stage and result buffering.
    mlkd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_pressed   (lane_pressed),
        .i_changed   (lane_changed),
        .i_level     (lane_level),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_pressed   (o_out.pressed_lines),
        .o_changed   (o_out.changed_switches),
        .o_levels    (o_out.switch_levels)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/mlkd_checker.sv =====
// Port-level checker of the debouncer and its bind to the top level.
`default_nettype none
module mlkd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_pressed,
    input wire logic [15:0] i_changed,
    input wire logic [15:0] i_levels
);

    logic        r_have_prev;
    logic [15:0] r_prev_levels;
    logic        take;

    assign take = i_out_valid && i_out_ready;

    // Switch levels of the last result that was transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (take) begin
            r_have_prev   <= 1'b1;
            r_prev_levels <= i_levels;
        end
    end

    // A result waiting on the output stays until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    // A line is never reported as both a press and a switch change.
    a_roles_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_pressed & i_changed) == 16'h0))
        else $error("line reported as press and switch change");

    // Switch levels move only on lines that are marked as changed.
    a_levels_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_have_prev) |-> (((i_levels ^ r_prev_levels) & ~i_changed) == 16'h0))
        else $error("switch level moved without a change flag");

    // Once a result leaves, the skid stage is free and the input is open.
    a_in_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> i_in_ready)
        else $error("input stayed closed after an output transfer");

endmodule

bind multi_line_key_debouncer mlkd_checker u_mlkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pressed   (o_out.pressed_lines),
    .i_changed   (o_out.changed_switches),
    .i_levels    (o_out.switch_levels)
);
`default_nettype wire

// ===== test/multi_line_key_debouncer_test.sv =====
// Self-checking testbench of the multi-line key debouncer with a built-in line predictor.
`timescale 1ns / 100ps

module multi_line_key_debouncer_test
    import mlkd_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_PCT    = 17;

    typedef struct packed {
        logic        operation;
        logic [15:0] line_levels;
    } t_scan_item;

    typedef struct packed {
        logic [15:0] pressed_lines;
        logic [15:0] changed_switches;
        logic [15:0] switch_levels;
    } t_line_report;

    // Clock, reset and configuration port.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_BUTTON_MASK;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Locally held channel drives.
    logic        drv_valid = 1'b0;
    logic        drv_op = OP_TICK;
    logic [15:0] drv_levels = '0;
    logic        rcv_ready = 1'b0;

    mlkd_in_if  in_ch ();
    mlkd_out_if out_ch ();

    assign in_ch.valid       = drv_valid;
    assign in_ch.operation   = drv_op;
    assign in_ch.line_levels = drv_levels;
    assign out_ch.ready      = rcv_ready;

    multi_line_key_debouncer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the registers and of the per-line debounce state.
    logic [15:0] btn_mask  = '0;
    logic [15:0] sw_mask   = '0;
    logic        press_lvl = 1'b0;
    logic [7:0]  deb_ticks = DEBOUNCE_RESET;
    logic        line_pend [16];
    logic [7:0]  line_cnt  [16];
    logic [1:0]  line_stab [16];
    logic [15:0] sw_bits   = '0;
    logic        armed     = 1'b0;

    t_scan_item   scan_items[$];
    t_line_report awaited_reports[$];
    t_scan_item   next_item;

    int n_pushed     = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int errors       = 0;
    int cycles       = 0;
    int n_settings   = 0;
    int hold_req     = 0;
    int holds_served = 0;
    int hold_left    = 0;
    bit calm         = 1'b0;

    // Random-content generator state: settled pin levels and an ongoing bounce.
    logic [15:0] pins        = '0;
    logic [15:0] bounce_mask = '0;
    int          bounce_left = 0;

    initial begin
        for (int n = 0; n < 16; n++) begin
            line_pend[n] = 1'b0;
            line_cnt[n]  = '0;
            line_stab[n] = '0;
        end
    end

    // Advance every line by one item and return the report it should cause.
    function automatic t_line_report debounce_step(logic op, logic [15:0] lv);
        t_line_report rep;
        logic         is_btn;
        logic         is_sw;
        logic         smp;
        rep = '0;
        for (int n = 0; n < 16; n++) begin
            is_btn = btn_mask[n];
            is_sw  = !is_btn && sw_mask[n];
            smp    = lv[n];
            if (op == OP_START) begin
                if (is_btn) begin
                    line_pend[n] = 1'b0;
                    line_cnt[n]  = '0;
                    line_stab[n] = {1'b0, smp};
                end else if (is_sw) begin
                    line_pend[n] = 1'b1;
                    line_cnt[n]  = deb_ticks - 8'd1;
                    line_stab[n] = UNKNOWN_LEVEL;
                end else begin
                    line_pend[n] = 1'b0;
                    line_cnt[n]  = '0;
                    line_stab[n] = '0;
                end
            end else if (armed && (is_btn || is_sw)) begin
                if (line_pend[n]) begin
                    line_cnt[n] = line_cnt[n] + 8'd1;
                    if (line_cnt[n] == deb_ticks) begin
                        if (line_stab[n] != {1'b0, smp}) begin
                            if (is_btn) begin
                                if (smp == press_lvl) rep.pressed_lines[n] = 1'b1;
                            end else begin
                                rep.changed_switches[n] = 1'b1;
                                sw_bits[n] = smp;
                            end
                        end
                        line_pend[n] = 1'b0;
                        line_cnt[n]  = '0;
                        line_stab[n] = {1'b0, smp};
                    end
                end else if (line_stab[n] != {1'b0, smp}) begin
                    line_pend[n] = 1'b1;
                end
            end
        end
        if (op == OP_START) armed = 1'b1;
        rep.switch_levels = sw_bits;
        return rep;
    endfunction

    // Driver: offers the next pending item, holding it until its transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_ch.ready) begin
            if (scan_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item = scan_items.pop_front();
                drv_valid  <= 1'b1;
                drv_op     <= next_item.operation;
                drv_levels <= next_item.line_levels;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Every input transfer advances the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            awaited_reports.push_back(debounce_step(in_ch.operation, in_ch.line_levels));
            n_accepted <= n_accepted + 1;
        end
    end

    // Receiver ready: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_ready <= 1'b1;
        end else if (hold_left != 0) begin
            rcv_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_req) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            rcv_ready    <= 1'b0;
        end else begin
            rcv_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endfunction

    // Monitor: compare each output transfer with the oldest predicted report.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: unexpected report: expected none, actual %h %h %h", $time,
                         out_ch.pressed_lines, out_ch.changed_switches, out_ch.switch_levels);
                errors++;
            end else begin
                check_field("pressed_lines", awaited_reports[0].pressed_lines,
                            out_ch.pressed_lines);
                check_field("changed_switches", awaited_reports[0].changed_switches,
                            out_ch.changed_switches);
                check_field("switch_levels", awaited_reports[0].switch_levels,
                            out_ch.switch_levels);
                void'(awaited_reports.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d reports outstanding.",
                     cycles, awaited_reports.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [15:0] lv);
        t_scan_item it;
        it.operation   = op;
        it.line_levels = lv;
        scan_items.push_back(it);
        n_pushed++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BUTTON_MASK:    btn_mask  = data;
            CFG_SWITCH_MASK:    sw_mask   = data;
            CFG_PRESSED_LEVEL:  press_lvl = data[0];
            CFG_DEBOUNCE_TICKS: deb_ticks = data[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_roles(logic [15:0] bm, logic [15:0] sm, logic pl, logic [7:0] dt);
        write_reg(CFG_BUTTON_MASK, bm);
        write_reg(CFG_SWITCH_MASK, sm);
        write_reg(CFG_PRESSED_LEVEL, {15'd0, pl});
        write_reg(CFG_DEBOUNCE_TICKS, {8'd0, dt});
        n_settings++;
    endtask

    // Wait until every item has been taken and every report has come back.
    task automatic drain;
        while (scan_items.size() != 0 || drv_valid || n_accepted != n_pushed ||
               awaited_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly settled pins with occasional bouncing edges, some noise and starts.
    task automatic add_random_items(int count);
        int          r;
        logic [15:0] lv;
        logic [15:0] flip;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                push_item(OP_START, pins);
            end else if (r < 11) begin
                push_item(OP_TICK, 16'($urandom_range(0, 65535)));
            end else begin
                if (bounce_left == 0 && $urandom_range(0, 99) < 20) begin
                    flip        = 16'($urandom_range(0, 65535)) &
                                  16'($urandom_range(0, 65535));
                    pins        = pins ^ flip;
                    bounce_mask = flip;
                    bounce_left = $urandom_range(0, 3);
                end
                lv = pins;
                if (bounce_left > 0) begin
                    lv = pins ^ (bounce_mask & 16'($urandom_range(0, 65535)));
                    bounce_left--;
                end
                push_item(OP_TICK, lv);
            end
        end
    endtask

    task automatic run_phase(logic [15:0] bm, logic [15:0] sm, logic pl, logic [7:0] dt,
                             int count, bit with_hold, bit quiet);
        set_roles(bm, sm, pl, dt);
        calm = quiet;
        add_random_items(count);
        if (with_hold) hold_req++;
        drain();
        calm = 1'b0;
    endtask

    // Stimulus sequencing: reset, directed items, then random phases.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ticks at reset settings, before any start.
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'hFFFF);
        drain();

        // Buttons on 0x0F0F, switches on 0xF000 (the overlap goes to the buttons).
        set_roles(16'h0F0F, 16'hFF00, 1'b1, 8'd2);
        push_item(OP_TICK, 16'hFFFF);
        push_item(OP_START, 16'h0000);
        push_item(OP_TICK, 16'h5555);
        push_item(OP_TICK, 16'h5555);
        push_item(OP_TICK, 16'h5555);
        push_item(OP_TICK, 16'hFFFF);
        push_item(OP_TICK, 16'hFFFF);
        push_item(OP_TICK, 16'hFFFF);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'h0000);
        // Bouncing button lines settle on the level seen at the resample.
        push_item(OP_TICK, 16'h000F);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'h000F);
        push_item(OP_TICK, 16'h000F);
        // A second start while lines are still pending.
        push_item(OP_TICK, 16'hF0F0);
        push_item(OP_START, 16'hFFFF);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'h0000);
        push_item(OP_TICK, 16'h0000);
        drain();

        run_phase(16'h00FF, 16'hFF0F, 1'b1, 8'd3, 100, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 1'b0, 8'd1, 150, 1'b1, 1'b0);
        run_phase(16'h0000, 16'hFFFF, 1'b1, 8'd255, 150, 1'b0, 1'b0);
        // Dropping to a short wait makes the long running counts wrap.
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0, 8'd2,
                  150, 1'b0, 1'b0);
        run_phase(16'h0000, 16'h0000, 1'b1, 8'd4, 60, 1'b0, 1'b0);
        // A zero wait behaves as 256 ticks.
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 8'd0, 300, 1'b1, 1'b0);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(1, 6)), 150, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 1'b1, 8'd7, 150, 1'b0, 1'b0);

        repeat (10) @(posedge i_clk);
        if (awaited_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, awaited_reports.size());
            errors++;
        end
        $display("Checked %0d reports for %0d transfers over %0d register settings,",
                 n_checked, n_accepted, n_settings);
        $display("including %0d long output stalls; %0d mismatches.", holds_served, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mlkd_pkg.sv
hw/rtl/mlkd_in_if.sv
hw/rtl/mlkd_out_if.sv
hw/rtl/mlkd_lane.sv
hw/rtl/mlkd_merge.sv
hw/rtl/multi_line_key_debouncer.sv
hw/rtl/mlkd_checker.sv
test/multi_line_key_debouncer_test.sv
